FILE: hw/rtl/blr_pkg.sv
// Shared types and constants of the line rasterizer.
// Used by the front, the queue, the back and the top level; depends on nothing.
package blr_pkg;

   localparam int FRAME_SIDE = 1024;
   localparam logic signed [16:0] FRAME_LIMIT = 17'(FRAME_SIDE);
   localparam logic signed [15:0] INVALID_X = -16'sd10000;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type            kind;
      logic               line_busy;
      logic signed [15:0] cur_x;
      logic signed [15:0] cur_y;
      logic [15:0]        end_major;
      logic               dir_x;
      logic               dir_y;
      logic [16:0]        twice_dx;
      logic [16:0]        twice_dy;
      logic               x_is_major;
      logic signed [18:0] error_term;
      logic [31:0]        color;
   } entry_type;

endpackage

FILE: hw/rtl/blr_req_if.sv
// Request channel of the line rasterizer: valid, ready and the command payload.
// Depends on nothing.
interface blr_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [15:0] start_x;
   logic signed [15:0] start_y;
   logic signed [15:0] end_x;
   logic signed [15:0] end_y;
   logic [31:0]        color;

   modport source (output valid, command, start_x, start_y, end_x, end_y, color,
                   input ready);
   modport sink (input valid, command, start_x, start_y, end_x, end_y, color,
                 output ready);
endinterface

FILE: hw/rtl/blr_rsp_if.sv
// Response channel of the line rasterizer: valid, ready and one pixel.
// Depends on nothing.
interface blr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pixel_x;
   logic signed [15:0] pixel_y;
   logic [19:0]        pixel_address;
   logic               write_enable;
   logic [31:0]        pixel_color;
   logic               last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_address, write_enable,
                   pixel_color, last_pixel, input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_address, write_enable,
                 pixel_color, last_pixel, output ready);
endinterface

FILE: hw/rtl/blr_front.sv
// Front end: accepts requests and queues each; a load carries the line setup.
// Depends on blr_pkg and blr_req_if.
module blr_front (
   blr_req_if.sink              req_chan,
   input  logic                 queue_full,
   output logic                 push,
   output blr_pkg::entry_type   entry
);

   logic signed [16:0] dx;
   logic signed [16:0] dy;
   logic [16:0]        abs_dx;
   logic [16:0]        abs_dy;
   logic [16:0]        twice_dx;
   logic [16:0]        twice_dy;
   logic               x_major;
   logic [15:0]        major_delta;

   assign req_chan.ready = !queue_full;
   assign push = req_chan.valid && !queue_full;

   always_comb begin
      dx = 17'(req_chan.end_x) - 17'(req_chan.start_x);
      dy = 17'(req_chan.end_y) - 17'(req_chan.start_y);
      abs_dx = dx[16] ? 17'(-dx) : 17'(dx);
      abs_dy = dy[16] ? 17'(-dy) : 17'(dy);
      twice_dx = {abs_dx[15:0], 1'b0};
      twice_dy = {abs_dy[15:0], 1'b0};
      x_major = twice_dx > twice_dy;
      major_delta = x_major ? abs_dx[15:0] : abs_dy[15:0];

      entry.kind = blr_pkg::cmd_type'(req_chan.command);
      entry.line_busy = (req_chan.start_x != blr_pkg::INVALID_X)
                        && (req_chan.end_x != blr_pkg::INVALID_X)
                        && (major_delta != 16'd0);
      entry.cur_x = req_chan.start_x;
      entry.cur_y = req_chan.start_y;
      entry.end_major = x_major ? req_chan.end_x : req_chan.end_y;
      entry.dir_x = !(dx > 17'sd0);
      entry.dir_y = !(dy > 17'sd0);
      entry.twice_dx = twice_dx;
      entry.twice_dy = twice_dy;
      entry.x_is_major = x_major;
      entry.error_term = 19'($signed({3'b000, major_delta}));
      entry.color = req_chan.color;
   end

endmodule

FILE: hw/rtl/blr_queue.sv
// Short queue of decoded requests between the front end and the stepper.
// Depends on blr_pkg.
module blr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  blr_pkg::entry_type   push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output blr_pkg::entry_type   head
);

   blr_pkg::entry_type                 slots_ff [blr_pkg::QUEUE_DEPTH];
   logic [blr_pkg::QPTR_W-1:0]         wr_ptr_ff;
   logic [blr_pkg::QPTR_W-1:0]         wr_ptr_in;
   logic [blr_pkg::QPTR_W-1:0]         rd_ptr_ff;
   logic [blr_pkg::QPTR_W-1:0]         rd_ptr_in;
   logic [blr_pkg::QCNT_W-1:0]         count_ff;
   logic [blr_pkg::QCNT_W-1:0]         count_in;
   logic                               do_push;
   logic                               do_pop;

   assign full = count_ff == blr_pkg::QCNT_W'(blr_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == blr_pkg::QPTR_W'(blr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == blr_pkg::QPTR_W'(blr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: hw/rtl/blr_back.sv
// Back end: holds the active line, steps it one pixel per cycle while the
// output is free, registering each pixel. Depends on blr_pkg and blr_rsp_if.
module blr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 entry_valid,
   input  blr_pkg::entry_type   entry,
   output logic                 pop,
   blr_rsp_if.source            rsp_chan
);

   logic                busy_ff, busy_in;
   logic signed [15:0]  cur_x_ff, cur_x_in;
   logic signed [15:0]  cur_y_ff, cur_y_in;
   logic [15:0]         end_major_ff, end_major_in;
   logic                dir_x_ff, dir_x_in;
   logic                dir_y_ff, dir_y_in;
   logic [16:0]         twice_dx_ff, twice_dx_in;
   logic [16:0]         twice_dy_ff, twice_dy_in;
   logic                x_major_ff, x_major_in;
   logic signed [18:0]  error_ff, error_in;
   logic [31:0]         color_ff, color_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]  out_x_ff, out_x_in;
   logic signed [15:0]  out_y_ff, out_y_in;
   logic [19:0]         out_addr_ff, out_addr_in;
   logic                out_we_ff, out_we_in;
   logic [31:0]         out_color_ff, out_color_in;
   logic                out_last_ff, out_last_in;

   logic                out_free;
   logic                is_load;
   logic                emit;
   logic [16:0]         dmin;
   logic [16:0]         dmaj;
   logic signed [18:0]  err_sub;
   logic                minor_step;
   logic signed [15:0]  x_step;
   logic signed [15:0]  y_step;
   logic signed [15:0]  next_x;
   logic signed [15:0]  next_y;
   logic [15:0]         major_now;
   logic                in_frame;
   logic [23:0]         full_addr;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign is_load = entry.kind == blr_pkg::CMD_LOAD;
   assign pop = entry_valid && (is_load || !busy_ff || out_free);
   assign emit = entry_valid && !is_load && busy_ff && out_free;

   always_comb begin
      dmin = x_major_ff ? twice_dy_ff : twice_dx_ff;
      dmaj = x_major_ff ? twice_dx_ff : twice_dy_ff;
      err_sub = error_ff - 19'($signed({2'b00, dmin}));
      minor_step = err_sub <= 19'sd0;
      x_step = dir_x_ff ? cur_x_ff - 16'sd1 : cur_x_ff + 16'sd1;
      y_step = dir_y_ff ? cur_y_ff - 16'sd1 : cur_y_ff + 16'sd1;
      next_x = (x_major_ff || minor_step) ? x_step : cur_x_ff;
      next_y = (!x_major_ff || minor_step) ? y_step : cur_y_ff;
      major_now = x_major_ff ? next_x : next_y;

      in_frame = (cur_x_ff > 16'sd0) && (17'(cur_x_ff) < blr_pkg::FRAME_LIMIT)
                 && (cur_y_ff > 16'sd0) && (17'(cur_y_ff) < blr_pkg::FRAME_LIMIT);
      full_addr = 24'(cur_x_ff[11:0])
                  + 24'(cur_y_ff[11:0]) * 24'(blr_pkg::FRAME_SIDE);
   end

   always_comb begin
      busy_in = busy_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      end_major_in = end_major_ff;
      dir_x_in = dir_x_ff;
      dir_y_in = dir_y_ff;
      twice_dx_in = twice_dx_ff;
      twice_dy_in = twice_dy_ff;
      x_major_in = x_major_ff;
      error_in = error_ff;
      color_in = color_ff;
      if (pop && is_load) begin
         busy_in = entry.line_busy;
         cur_x_in = entry.cur_x;
         cur_y_in = entry.cur_y;
         end_major_in = entry.end_major;
         dir_x_in = entry.dir_x;
         dir_y_in = entry.dir_y;
         twice_dx_in = entry.twice_dx;
         twice_dy_in = entry.twice_dy;
         x_major_in = entry.x_is_major;
         error_in = entry.error_term;
         color_in = entry.color;
      end else if (emit) begin
         cur_x_in = next_x;
         cur_y_in = next_y;
         error_in = minor_step ? err_sub + 19'($signed({2'b00, dmaj})) : err_sub;
         busy_in = major_now != end_major_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_addr_in = out_addr_ff;
      out_we_in = out_we_ff;
      out_color_in = out_color_ff;
      out_last_in = out_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         out_x_in = cur_x_ff;
         out_y_in = cur_y_ff;
         out_addr_in = in_frame ? full_addr[19:0] : 20'd0;
         out_we_in = in_frame;
         out_color_in = color_ff;
         out_last_in = major_now == end_major_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      end_major_ff <= end_major_in;
      dir_x_ff <= dir_x_in;
      dir_y_ff <= dir_y_in;
      twice_dx_ff <= twice_dx_in;
      twice_dy_ff <= twice_dy_in;
      x_major_ff <= x_major_in;
      error_ff <= error_in;
      color_ff <= color_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_addr_ff <= out_addr_in;
      out_we_ff <= out_we_in;
      out_color_ff <= out_color_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pixel_x = out_x_ff;
   assign rsp_chan.pixel_y = out_y_ff;
   assign rsp_chan.pixel_address = out_addr_ff;
   assign rsp_chan.write_enable = out_we_ff;
   assign rsp_chan.pixel_color = out_color_ff;
   assign rsp_chan.last_pixel = out_last_ff;

endmodule

FILE: hw/rtl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer. A request is accepted every cycle while the
// two-entry queue has room; a step request waits in the queue, then its
// pixel is registered; one pixel leaves per cycle while the output is taken.
// The stepper's error update (one subtract, compare and add) sets that rate.
// Synchronous reset empties the queue, drops the active line and the pending
// pixel; the block is ready again in the first cycle after reset.
module bresenham_line_rasterizer (
   input  logic      clock,
   input  logic      reset,
   blr_req_if.sink   req_chan,
   blr_rsp_if.source rsp_chan
);

   logic               push;
   logic               queue_full;
   logic               queue_valid;
   logic               pop;
   blr_pkg::entry_type push_entry;
   blr_pkg::entry_type head_entry;

   blr_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .entry      (push_entry)
   );

   blr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_valid),
      .head       (head_entry)
   );

   blr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (queue_valid),
      .entry       (head_entry),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule
